>>> sv/ael_pkg.sv
// ----------------------------------------------------------------------------
// ael_pkg
// Shared types, constants and byte classifiers for the expression lexer.
// ----------------------------------------------------------------------------
package ael_pkg;

	localparam int INDEX_BITS = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [INDEX_BITS-1:0] POS_MAX = '1;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		K_INT = 2'd0,
		K_OP  = 2'd1,
		K_END = 2'd2,
		K_ERR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_PLUS  = 3'd0,
		OP_MINUS = 3'd1,
		OP_TIMES = 3'd2,
		OP_DIV   = 3'd3,
		OP_OPEN  = 3'd4,
		OP_CLOSE = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_NUM  = 4'b0010,
		PH_ZERO = 4'b0100,
		PH_ERR  = 4'b1000
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] start_index;
		logic [15:0] token_length;
		logic [63:0] value;
		op_t         op_code;
		logic [7:0]  bad_char;
		logic        last;
	} res_t;

	// up to two results per beat, slot r0 first
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_OPEN, CH_CLOSE};
	endfunction

	function automatic op_t op_of(input logic [7:0] c);
		op_t o;
		case (c)
			CH_PLUS:  o = OP_PLUS;
			CH_MINUS: o = OP_MINUS;
			CH_STAR:  o = OP_TIMES;
			CH_SLASH: o = OP_DIV;
			CH_OPEN:  o = OP_OPEN;
			CH_CLOSE: o = OP_CLOSE;
			default:  o = OP_PLUS;
		endcase
		return o;
	endfunction

endpackage

>>> sv/ael_in_if.sv
// ----------------------------------------------------------------------------
// ael_in_if
// Source byte channel: valid/ready with byte and end-of-source marker.
// ----------------------------------------------------------------------------
interface ael_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_source;

	modport source (output valid, ch, end_of_source, input ready);
	modport sink (input valid, ch, end_of_source, output ready);
endinterface

>>> sv/ael_out_if.sv
// ----------------------------------------------------------------------------
// ael_out_if
// Token channel: valid/ready with one lexer result per beat.
// ----------------------------------------------------------------------------
interface ael_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] start_index;
	logic [15:0] token_length;
	logic [63:0] value;
	logic [2:0]  op_code;
	logic [7:0]  bad_char;
	logic        last;

	modport source (output valid, kind, start_index, token_length, value, op_code,
		bad_char, last, input ready);
	modport sink (input valid, kind, start_index, token_length, value, op_code,
		bad_char, last, output ready);
endinterface

>>> sv/ael_core.sv
// ----------------------------------------------------------------------------
// ael_core
// Input register, lexer state and single-pass classify/accumulate logic.
// ----------------------------------------------------------------------------
module ael_core (
	input  logic           clk,
	input  logic           arst_n,
	ael_in_if.sink         src,
	input  logic           room,
	output ael_pkg::push_t push
);
	import ael_pkg::*;

	logic                  valid_s1;
	logic [7:0]            ch_s1;
	logic                  eos_s1;
	logic                  adv;

	phase_t                phase_q, phase_n;
	logic [INDEX_BITS-1:0] pos_q, pos_n, pos_inc;
	logic [INDEX_BITS-1:0] tstart_q, tstart_n;
	logic [63:0]           acc_q, acc_n;

	logic [67:0]           acc_wide;
	logic [7:0]            dig;
	res_t                  lit, idle_res;
	logic                  idle_emit;
	logic                  flush;

	assign adv       = valid_s1 && room;
	assign src.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			ch_s1  <= src.ch;
			eos_s1 <= src.end_of_source;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			tstart_q <= '0;
			acc_q    <= '0;
		end else if (adv) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			tstart_q <= tstart_n;
			acc_q    <= acc_n;
		end
	end

	assign pos_inc  = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
	assign dig      = ch_s1 - CH_ZERO;
	// acc*10 + digit as two shifted adds; any carry past bit 63 saturates
	assign acc_wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {64'b0, dig[3:0]};

	always_comb begin
		lit              = '0;
		lit.kind         = K_INT;
		lit.start_index  = 16'(tstart_q);
		lit.token_length = 16'(pos_q - tstart_q);
		lit.value        = acc_q;
	end

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		tstart_n  = tstart_q;
		acc_n     = acc_q;
		push      = '0;
		idle_res  = '0;
		idle_emit = 1'b0;
		flush     = 1'b0;

		if (phase_q == PH_ERR) begin
			if (eos_s1) begin
				phase_n  = PH_IDLE;
				pos_n    = '0;
				tstart_n = '0;
				acc_n    = '0;
			end
		end else if (eos_s1) begin
			idle_res.kind        = K_END;
			idle_res.start_index = 16'(pos_q);
			idle_emit            = 1'b1;
			flush                = (phase_q == PH_NUM) || (phase_q == PH_ZERO);
			phase_n              = PH_IDLE;
			pos_n                = '0;
			tstart_n             = '0;
			acc_n                = '0;
		end else if (phase_q == PH_ZERO && is_digit(ch_s1)) begin
			// multi-digit literal with a leading zero
			idle_res.kind        = K_ERR;
			idle_res.start_index = 16'(tstart_q);
			idle_res.bad_char    = CH_ZERO;
			idle_emit            = 1'b1;
			phase_n              = PH_ERR;
		end else if (phase_q == PH_NUM && is_digit(ch_s1)) begin
			acc_n = (|acc_wide[67:64]) ? '1 : acc_wide[63:0];
			pos_n = pos_inc;
		end else begin
			flush   = (phase_q == PH_NUM) || (phase_q == PH_ZERO);
			phase_n = PH_IDLE;
			acc_n   = '0;
			if (is_space(ch_s1)) begin
				pos_n = pos_inc;
			end else if (ch_s1 == CH_ZERO) begin
				phase_n  = PH_ZERO;
				tstart_n = pos_q;
				pos_n    = pos_inc;
			end else if (is_digit(ch_s1)) begin
				phase_n  = PH_NUM;
				tstart_n = pos_q;
				acc_n    = {60'b0, dig[3:0]};
				pos_n    = pos_inc;
			end else if (is_op(ch_s1)) begin
				idle_res.kind         = K_OP;
				idle_res.start_index  = 16'(pos_q);
				idle_res.token_length = 16'd1;
				idle_res.op_code      = op_of(ch_s1);
				idle_emit             = 1'b1;
				pos_n                 = pos_inc;
			end else begin
				idle_res.kind        = K_ERR;
				idle_res.start_index = 16'(pos_q);
				idle_res.bad_char    = ch_s1;
				idle_emit            = 1'b1;
				phase_n              = PH_ERR;
			end
		end

		if (adv) begin
			if (flush) begin
				push.r0      = lit;
				push.r0.last = !idle_emit;
				push.r1      = idle_res;
				push.r1.last = 1'b1;
				push.n       = idle_emit ? 2'd2 : 2'd1;
			end else if (idle_emit) begin
				push.r0      = idle_res;
				push.r0.last = 1'b1;
				push.n       = 2'd1;
			end
		end
	end

	a_acc_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> acc_q == '0)
		else $error("accumulator not cleared in idle phase");

	a_start_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		tstart_q <= pos_q)
		else $error("token start beyond position");

	a_err_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv && phase_q == PH_ERR |-> push.n == 2'd0)
		else $error("result produced while discarding after error");

	a_pos_mono: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !eos_s1 && phase_q != PH_ERR |=> pos_q >= $past(pos_q))
		else $error("position moved backward");

endmodule

>>> sv/ael_result_fifo.sv
// ----------------------------------------------------------------------------
// ael_result_fifo
// Four-entry result queue: up to two writes per cycle, one beat out.
// ----------------------------------------------------------------------------
module ael_result_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  ael_pkg::push_t push,
	output logic          room,
	ael_out_if.source     tok
);
	import ael_pkg::*;

	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               pop;
	res_t               head;

	assign pop  = tok.valid && tok.ready;
	assign room = cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_AW'(push.n);
			rd_q  <= rd_q + FIFO_AW'(pop);
			cnt_q <= cnt_q + (FIFO_AW+1)'(push.n) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + 1'b1] <= push.r1;
		end
	end

	assign tok.valid        = cnt_q != '0;
	assign tok.kind         = head.kind;
	assign tok.start_index  = head.start_index;
	assign tok.token_length = head.token_length;
	assign tok.value        = head.value;
	assign tok.op_code      = head.op_code;
	assign tok.bad_char     = head.bad_char;
	assign tok.last         = head.last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("push without room");

	a_pop_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.n == 2'd0 |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop did not drain queue");

endmodule

>>> sv/arithmetic_expression_lexer.sv
// ----------------------------------------------------------------------------
// arithmetic_expression_lexer
// Integer and operator lexer for arithmetic text, one source byte per beat.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  src      in   valid/ready   ch, end_of_source
//  tok      out  valid/ready   kind, start_index, token_length, value,
//                              op_code, bad_char, last
//
//  One source beat per cycle while the queue has room; results pass s1 and the queue.
//  A beat that yields two tokens (literal then operator, end or error) occupies
//  the output for two beats; the four-entry result queue sets that limit.
//  src.ready drops only while the queue holds more than two tokens.
//  arst_n clears the lexer state and the queue; no clearing pass.
// ----------------------------------------------------------------------------
module arithmetic_expression_lexer (
	input  logic      clk,
	input  logic      arst_n,
	ael_in_if.sink    src,
	ael_out_if.source tok
);
	import ael_pkg::*;

	push_t push;
	logic  room;

	ael_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.room   (room),
		.push   (push)
	);

	ael_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tok    (tok)
	);

endmodule
